// ===== src/bcv_pkg.sv =====
// shared types and curve constants for the battery charge estimator
// no dependencies; imported by every module of the block
package bcv_pkg;

    localparam int VoltW    = 13;
    localparam int LevelW   = 7;
    localparam int RiseW    = 4;
    localparam int AboveW   = 7;
    localparam int RecipW   = 14;
    localparam int ProdW    = 11;
    localparam int QuotW    = 4;
    localparam int RecipSh  = 20;
    localparam int CurvePts = 11;

    localparam logic [LevelW-1:0] FullLevel = 7'd100;
    localparam logic [LevelW-1:0] ZeroLevel = 7'd0;

    localparam logic [VoltW-1:0] CurveVolt [0:CurvePts-1] = '{
        13'd4200, 13'd4100, 13'd4000, 13'd3920, 13'd3850, 13'd3780,
        13'd3700, 13'd3600, 13'd3500, 13'd3400, 13'd3300
    };

    localparam logic [LevelW-1:0] CurveLevel [0:CurvePts-1] = '{
        7'd100, 7'd90, 7'd78, 7'd65, 7'd50, 7'd35,
        7'd22, 7'd12, 7'd6, 7'd2, 7'd0
    };

    // ceil(2^20 / segment width) for the segment whose lower point is k
    localparam logic [RecipW-1:0] CurveRecip [0:CurvePts-1] = '{
        14'd0, 14'd10486, 14'd10486, 14'd13108, 14'd14980, 14'd14980,
        14'd13108, 14'd10486, 14'd10486, 14'd10486, 14'd10486
    };

    typedef struct packed {
        logic [LevelW-1:0] base;
        logic [RiseW-1:0]  rise;
        logic [AboveW-1:0] above;
        logic [RecipW-1:0] recip;
    } t_seg;

    typedef struct packed {
        logic [LevelW-1:0] base;
        logic [ProdW-1:0]  prod;
        logic [RecipW-1:0] recip;
    } t_prod;

    typedef struct packed {
        logic [LevelW-1:0] base;
        logic [QuotW-1:0]  quot;
    } t_quot;

endpackage

// ===== src/bcv_seg.sv =====
// first stage: finds the curve segment for a voltage and registers its terms
// depends on bcv_pkg
module bcv_seg (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [bcv_pkg::VoltW-1:0] i_volt,
    output bcv_pkg::t_seg             o_seg
);
    import bcv_pkg::*;

    t_seg              n_seg;
    t_seg              r_seg;
    logic [VoltW-1:0]  w_diff;

    always_comb begin
        n_seg  = '0;
        w_diff = '0;
        if (i_volt >= CurveVolt[0]) begin
            n_seg.base = FullLevel;
        end else if (i_volt <= CurveVolt[CurvePts-1]) begin
            n_seg.base = ZeroLevel;
        end else begin
            // walk upward; the last match, the highest point at or below, wins
            for (int k = CurvePts - 1; k >= 1; k--) begin
                if (i_volt >= CurveVolt[k]) begin
                    w_diff      = i_volt - CurveVolt[k];
                    n_seg.base  = CurveLevel[k];
                    n_seg.rise  = RiseW'(CurveLevel[k-1] - CurveLevel[k]);
                    n_seg.above = w_diff[AboveW-1:0];
                    n_seg.recip = CurveRecip[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

// ===== src/bcv_mul.sv =====
// second and third stages: rise times offset, then divide by segment width
// through a reciprocal multiply; depends on bcv_pkg
module bcv_mul (
    input  logic           i_clk,
    input  logic           i_en_prod,
    input  logic           i_en_quot,
    input  bcv_pkg::t_seg  i_seg,
    output bcv_pkg::t_quot o_quot
);
    import bcv_pkg::*;

    t_prod                        r_prod;
    t_quot                        r_quot;
    logic [ProdW+RecipW-1:0]      w_scaled;

    always_ff @(posedge i_clk) begin
        if (i_en_prod) begin
            r_prod.base  <= i_seg.base;
            r_prod.prod  <= ProdW'(i_seg.rise * i_seg.above);
            r_prod.recip <= i_seg.recip;
        end
    end

    // product stays below 1500, so the shifted reciprocal product is exact
    assign w_scaled = (ProdW+RecipW)'(r_prod.prod * r_prod.recip);

    always_ff @(posedge i_clk) begin
        if (i_en_quot) begin
            r_quot.base <= r_prod.base;
            r_quot.quot <= w_scaled[RecipSh +: QuotW];
        end
    end

    assign o_quot = r_quot;

endmodule

// ===== src/battery_charge_from_voltage_top.sv =====
// top level of the battery charge estimator: stream ports, stage valids, output stage
// depends on bcv_pkg, bcv_seg and bcv_mul
//
// Maps a battery voltage in millivolts to a state of charge in whole percent by
// linear interpolation over an eleven-point discharge curve (100 % at 4200 mV
// and above, 0 % at 3300 mV and below). The block is a four-register pipeline:
// segment search, rise-times-offset multiply, reciprocal multiply for the
// division by the segment width, then add and clamp into the output register.
// It accepts one beat per cycle while the output does not stall; a beat moves
// from the segment to the product, quotient and output registers. Stalls ripple
// back through the stage valids, and empty stages are filled without waiting.
module battery_charge_from_voltage_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [12:0] voltage_mv, [15:13] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [6:0] charge_percent, [7] zero
);
    import bcv_pkg::*;

    logic [2:0]         r_vld;
    logic               r_out_vld;
    logic [LevelW-1:0]  r_out;
    logic [LevelW-1:0]  n_out;
    logic [LevelW:0]    w_sum;
    logic [3:0]         w_adv;
    t_seg               w_seg;
    t_quot              w_quot;

    // a stage loads when it is empty or its contents move on
    assign w_adv[3] = !r_out_vld || i_m_tready;
    assign w_adv[2] = !r_vld[2] || w_adv[3];
    assign w_adv[1] = !r_vld[1] || w_adv[2];
    assign w_adv[0] = !r_vld[0] || w_adv[1];

    bcv_seg u_seg (
        .i_clk  (i_clk),
        .i_en   (w_adv[0]),
        .i_volt (i_s_tdata[VoltW-1:0]),
        .o_seg  (w_seg)
    );

    bcv_mul u_mul (
        .i_clk     (i_clk),
        .i_en_prod (w_adv[1]),
        .i_en_quot (w_adv[2]),
        .i_seg     (w_seg),
        .o_quot    (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_s_tvalid;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
            if (w_adv[3]) r_out_vld <= r_vld[2];
        end
    end

    assign w_sum = {1'b0, w_quot.base} + {{(LevelW+1-QuotW){1'b0}}, w_quot.quot};

    always_comb begin
        if (w_sum > {1'b0, FullLevel}) begin
            n_out = FullLevel;
        end else begin
            n_out = w_sum[LevelW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_out <= n_out;
        end
    end

    assign o_s_tready = w_adv[0];
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out};

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out <= FullLevel)
        else $error("charge result above full scale");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_vld == 3'b111) && r_out_vld && !i_m_tready)
        else $error("input stalled while a stage is free");

    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tdata[VoltW-1:0] >= CurveVolt[0])
        |=> r_vld[0] && w_seg.rise == '0 && w_seg.base == FullLevel)
        else $error("full-scale voltage not saturated");

    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tdata[VoltW-1:0] <= CurveVolt[CurvePts-1])
        |=> r_vld[0] && w_seg.rise == '0 && w_seg.base == ZeroLevel)
        else $error("empty-scale voltage not floored");

endmodule
